>>> rtl/kstrr_pkg.sv
// Shared definitions for the keyed slot table with round-robin poll.
// Holds the operation codes and the default sizing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kstrr_pkg;

    typedef enum logic [1:0] {
        OP_REG_GEN = 2'd0,
        OP_REG_RSV = 2'd1,
        OP_UNREG   = 2'd2,
        OP_POLL    = 2'd3
    } op_t;

    localparam int DEF_GENERAL_SLOTS  = 12;
    localparam int DEF_RESERVED_SLOTS = 4;
    localparam int DEF_KEY_WIDTH      = 32;

    // Widths of the ports, fixed by the word format
    localparam int IN_KEY_W   = 32;
    localparam int RIDX_W     = 4;
    localparam int LIMIT_W    = 5;
    localparam int MASK_W     = 16;
    localparam int CNT_OUT_W  = 5;

endpackage

`default_nettype wire

>>> rtl/keyed_slot_table_round_robin_poll.sv
// Top level of the keyed slot table with round-robin poll.
// Depends on kstrr_pkg for operation codes and default sizes.
`timescale 1ns / 1ps
`default_nettype none

// The table takes one command word while busy is low and start is high,
// then works on it alone until it reports: busy stays high the whole time.
// Each command returns exactly one result word, shown for one cycle with
// done high; the receiver cannot hold it off, so capture it on that cycle.
// The result appears in the cycle in which busy has just fallen, so a new
// command may be started in that same cycle. Slot keys live in a one-write,
// one-read memory scanned one slot per cycle; the valid bits are flip-flops.
// From accept to report: a failing command (handler zero, reserved index
// out of range) or an empty/zero-batch poll goes straight to the report
// state, as does register reserved into a free slot; into an occupied slot
// it first reads and compares that one slot. Register general scans the
// general slots and unregister all slots, both through the one memory read
// port; a poll visits up to GENERAL_SLOTS + RESERVED_SLOTS slots, one per
// cycle. No clearing pass runs after reset: invalid slots are never matched.
module keyed_slot_table_round_robin_poll #(
    parameter int GENERAL_SLOTS  = kstrr_pkg::DEF_GENERAL_SLOTS,
    parameter int RESERVED_SLOTS = kstrr_pkg::DEF_RESERVED_SLOTS,
    parameter int KEY_WIDTH      = kstrr_pkg::DEF_KEY_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        op,
    input  wire logic [kstrr_pkg::IN_KEY_W-1:0]    key_handler,
    input  wire logic [kstrr_pkg::IN_KEY_W-1:0]    key_context,
    input  wire logic [kstrr_pkg::RIDX_W-1:0]      reserved_index,
    input  wire logic [kstrr_pkg::LIMIT_W-1:0]     poll_budget,
    input  wire logic [kstrr_pkg::MASK_W-1:0]      done_mask,
    output logic                                   done,
    output logic                                   ok,
    output logic [kstrr_pkg::CNT_OUT_W-1:0]        completed,
    output logic [kstrr_pkg::CNT_OUT_W-1:0]        attempted,
    output logic [kstrr_pkg::CNT_OUT_W-1:0]        pending_count
);
    import kstrr_pkg::*;

    localparam int TOTAL = GENERAL_SLOTS + RESERVED_SLOTS;
    localparam int IW    = $clog2(TOTAL);
    localparam int CW    = $clog2(TOTAL + 1);
    // Stored key width: only the low KEY_WIDTH bits of a 32-bit field count
    localparam int SKW   = (KEY_WIDTH < IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;
    // Slots that own a done bit
    localparam int DW    = (TOTAL < MASK_W) ? TOTAL : MASK_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POLL,
        S_REPORT
    } state_t;

    state_t                 state_reg;
    logic [1:0]             op_reg;
    logic [2*SKW-1:0]       key_reg;        // {context, handler}
    logic [LIMIT_W-1:0]     limit_reg;
    logic [TOTAL-1:0]       mask_reg;       // done bits spread over slots
    logic [TOTAL-1:0]       slot_valid_reg;
    logic [CW-1:0]          active_reg;
    logic [IW-1:0]          cursor_reg;

    // Scan sequencer
    logic [IW-1:0]          rd_idx_reg;
    logic [IW-1:0]          rd_hi_reg;
    logic                   issued_all_reg;
    logic                   cmp_vld_reg;
    logic [IW-1:0]          cmp_idx_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;

    // Poll sequencer
    logic [IW-1:0]          poll_idx_reg;
    logic [CW-1:0]          scanned_reg;

    // Key memory
    logic [2*SKW-1:0]       key_mem [TOTAL];
    logic [2*SKW-1:0]       rdata_reg;
    logic                   wr_en_reg;
    logic [IW-1:0]          wr_addr_reg;

    // Result word
    logic                   done_reg;
    logic                   ok_reg;
    logic [CNT_OUT_W-1:0]   cmpl_reg;
    logic [CNT_OUT_W-1:0]   att_reg;
    logic [CNT_OUT_W-1:0]   pend_reg;

    logic [SKW-1:0]         in_h;
    logic [SKW-1:0]         in_c;
    logic                   h_zero;
    logic [IW-1:0]          rsv_slot;
    logic                   rsv_in_range;
    logic                   hit;
    logic                   poll_go;
    logic [IW-1:0]          poll_wrap;
    logic [IW-1:0]          rd_step;

    assign in_h         = key_handler[SKW-1:0];
    assign in_c         = key_context[SKW-1:0];
    assign h_zero       = (in_h == '0);
    assign rsv_slot     = IW'(GENERAL_SLOTS) + IW'(reserved_index);
    assign rsv_in_range = ({1'b0, reserved_index} < (RIDX_W + 1)'(RESERVED_SLOTS));

    // Compare the word read last cycle against the command key
    assign hit = cmp_vld_reg && slot_valid_reg[cmp_idx_reg] && (rdata_reg == key_reg);

    // Poll continues while batch, pass length and table contents allow
    assign poll_go   = (att_reg < limit_reg) && (scanned_reg < CW'(TOTAL))
                       && (active_reg != '0);
    assign poll_wrap = (poll_idx_reg == IW'(TOTAL - 1)) ? '0 : poll_idx_reg + 1'b1;
    assign rd_step   = rd_idx_reg + 1'b1;

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign ok            = ok_reg;
    assign completed     = cmpl_reg;
    assign attempted     = att_reg;
    assign pending_count = pend_reg;

    // Key memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            key_mem[wr_addr_reg] <= key_reg;
        end
        rdata_reg <= key_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            active_reg     <= '0;
            cursor_reg     <= '0;
            done_reg       <= 1'b0;
            wr_en_reg      <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            issued_all_reg <= 1'b0;
            free_found_reg <= 1'b0;
            ok_reg         <= 1'b0;
            cmpl_reg       <= '0;
            att_reg        <= '0;
            pend_reg       <= '0;
            op_reg         <= OP_REG_GEN;
            key_reg        <= '0;
            limit_reg      <= '0;
            mask_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_hi_reg      <= '0;
            cmp_idx_reg    <= '0;
            free_idx_reg   <= '0;
            poll_idx_reg   <= '0;
            scanned_reg    <= '0;
            wr_addr_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // Drop the strobe of the word just reported
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        // Latch the command word and clear the result
                        op_reg         <= op;
                        key_reg        <= {in_c, in_h};
                        limit_reg      <= poll_budget;
                        mask_reg       <= TOTAL'(done_mask[DW-1:0]);
                        ok_reg         <= 1'b0;
                        cmpl_reg       <= '0;
                        att_reg        <= '0;
                        cmp_vld_reg    <= 1'b0;
                        issued_all_reg <= 1'b0;
                        free_found_reg <= 1'b0;

                        unique case (op)
                            OP_REG_GEN:
                            begin
                                if (!h_zero)
                                begin
                                    rd_idx_reg <= '0;
                                    rd_hi_reg  <= IW'(GENERAL_SLOTS - 1);
                                    state_reg  <= S_SCAN;
                                end
                                else
                                begin
                                    state_reg <= S_REPORT;
                                end
                            end
                            OP_REG_RSV:
                            begin
                                if (!h_zero && rsv_in_range)
                                begin
                                    if (slot_valid_reg[rsv_slot])
                                    begin
                                        // Occupied: succeed only on a key match
                                        rd_idx_reg <= rsv_slot;
                                        rd_hi_reg  <= rsv_slot;
                                        state_reg  <= S_SCAN;
                                    end
                                    else
                                    begin
                                        slot_valid_reg[rsv_slot] <= 1'b1;
                                        active_reg  <= active_reg + 1'b1;
                                        wr_en_reg   <= 1'b1;
                                        wr_addr_reg <= rsv_slot;
                                        ok_reg      <= 1'b1;
                                        state_reg   <= S_REPORT;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_REPORT;
                                end
                            end
                            OP_UNREG:
                            begin
                                if (!h_zero)
                                begin
                                    rd_idx_reg <= '0;
                                    rd_hi_reg  <= IW'(TOTAL - 1);
                                    state_reg  <= S_SCAN;
                                end
                                else
                                begin
                                    state_reg <= S_REPORT;
                                end
                            end
                            OP_POLL:
                            begin
                                if (active_reg != '0 && poll_budget != '0)
                                begin
                                    poll_idx_reg <= cursor_reg;
                                    scanned_reg  <= '0;
                                    state_reg    <= S_POLL;
                                end
                                else
                                begin
                                    state_reg <= S_REPORT;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_REPORT;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (hit)
                    begin
                        ok_reg    <= 1'b1;
                        state_reg <= S_REPORT;
                        if (op_reg == OP_UNREG)
                        begin
                            // Drop the first matching entry
                            slot_valid_reg[cmp_idx_reg] <= 1'b0;
                            active_reg <= active_reg - 1'b1;
                            if (active_reg == CW'(1))
                            begin
                                cursor_reg <= '0;
                            end
                        end
                    end
                    else if (cmp_vld_reg && op_reg == OP_REG_RSV)
                    begin
                        state_reg <= S_REPORT;
                    end
                    else if (!issued_all_reg)
                    begin
                        // Issue the next read and track the lowest free slot
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= rd_idx_reg;
                        if (op_reg == OP_REG_GEN && !slot_valid_reg[rd_idx_reg]
                            && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_idx_reg;
                        end
                        if (rd_idx_reg == rd_hi_reg)
                        begin
                            issued_all_reg <= 1'b1;
                        end
                        else
                        begin
                            rd_idx_reg <= rd_step;
                        end
                    end
                    else
                    begin
                        // Last compare missed: fill a free general slot if any
                        state_reg <= S_REPORT;
                        if (op_reg == OP_REG_GEN && free_found_reg)
                        begin
                            slot_valid_reg[free_idx_reg] <= 1'b1;
                            active_reg  <= active_reg + 1'b1;
                            wr_en_reg   <= 1'b1;
                            wr_addr_reg <= free_idx_reg;
                            ok_reg      <= 1'b1;
                        end
                    end
                end

                S_POLL:
                begin
                    if (poll_go)
                    begin
                        poll_idx_reg <= poll_wrap;
                        scanned_reg  <= scanned_reg + 1'b1;
                        if (slot_valid_reg[poll_idx_reg])
                        begin
                            att_reg <= att_reg + 1'b1;
                            if (mask_reg[poll_idx_reg])
                            begin
                                slot_valid_reg[poll_idx_reg] <= 1'b0;
                                active_reg <= active_reg - 1'b1;
                                cmpl_reg   <= cmpl_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        cursor_reg <= (active_reg == '0) ? '0 : poll_idx_reg;
                        state_reg  <= S_REPORT;
                    end
                end

                S_REPORT:
                begin
                    // The key write, if any, lands at this edge
                    wr_en_reg <= 1'b0;
                    done_reg  <= 1'b1;
                    pend_reg  <= CNT_OUT_W'(active_reg);
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
